[hdl/brs_pkg.sv]
// Shared types and constants for the blocked range-add / range-sum engine.
// Used by brs_alu, brs_seq and block_range_add_range_sum; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int BLOCK_SIZE   = 32;
    localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int OFF_W   = $clog2(BLOCK_SIZE);
    localparam int BLK_W   = $clog2(NUM_BLOCKS);
    localparam int POS_W   = IDX_W + 1;
    localparam int FIELD_W = 11;
    localparam int DATA_W  = 64;
    localparam int OP_W    = 2;

    localparam logic [FIELD_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [FIELD_W-1:0] COUNT_MAX   = FIELD_W'(MAX_ELEMENTS);

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC1,
        ST_EXEC2,
        ST_EXEC3,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        A_V,
        A_ELEM,
        A_SUM,
        A_TMP,
        A_ACC
    } t_asel;

    typedef enum logic [2:0] {
        B_TAG,
        B_TAG32,
        B_V,
        B_ELEM,
        B_TMP
    } t_bsel;

    // Sequencer to datapath.
    typedef struct packed {
        logic  ready;
        logic  clearing;
        t_asel asel;
        t_bsel bsel;
        logic  alu_sub;
        logic  ld_tmp;
        logic  ld_acc;
        logic  wr_elem;
        logic  elem_from_tmp;
        logic  wr_tag;
        logic  wr_sum;
        logic  advance;
        logic  out_load;
    } t_ctrl;

    // Datapath to sequencer.
    typedef struct packed {
        logic            accept;
        logic            bad;
        logic            clr_done;
        logic [OP_W-1:0] op;
        logic            whole;
        logic            range_end;
        logic            out_free;
    } t_stat;

endpackage

`default_nettype wire

[hdl/brs_alu.sv]
// Shared 64-bit add/subtract unit with its operand selection.
// Depends on brs_pkg for the operand select codes.
`timescale 1ns / 1ps
`default_nettype none

module brs_alu (
    input  wire brs_pkg::t_asel             i_asel,
    input  wire brs_pkg::t_bsel             i_bsel,
    input  wire                             i_sub,
    input  wire [brs_pkg::DATA_W-1:0]       i_v,
    input  wire [brs_pkg::DATA_W-1:0]       i_elem,
    input  wire [brs_pkg::DATA_W-1:0]       i_sum,
    input  wire [brs_pkg::DATA_W-1:0]       i_tag,
    input  wire [brs_pkg::DATA_W-1:0]       i_tmp,
    input  wire [brs_pkg::DATA_W-1:0]       i_acc,
    output logic [brs_pkg::DATA_W-1:0]      o_y
);
    import brs_pkg::*;

    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;

    always_comb begin
        unique case (i_asel)
            A_V:     a = i_v;
            A_ELEM:  a = i_elem;
            A_SUM:   a = i_sum;
            A_TMP:   a = i_tmp;
            A_ACC:   a = i_acc;
            default: a = '0;
        endcase
    end

    always_comb begin
        unique case (i_bsel)
            B_TAG:   b = i_tag;
            // A whole block holds BLOCK_SIZE copies of its tag.
            B_TAG32: b = {i_tag[DATA_W-OFF_W-1:0], {OFF_W{1'b0}}};
            B_V:     b = i_v;
            B_ELEM:  b = i_elem;
            B_TMP:   b = i_tmp;
            default: b = '0;
        endcase
    end

    assign o_y = i_sub ? (a - b) : (a + b);

endmodule

`default_nettype wire

[hdl/brs_seq.sv]
// Sequencer for the range engine: clearing pass, per-element and per-block steps.
// Depends on brs_pkg for the state, control and status types.
`timescale 1ns / 1ps
`default_nettype none

module brs_seq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire brs_pkg::t_stat i_stat,
    output brs_pkg::t_ctrl o_ctrl
);
    import brs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_stat.accept) n_state = i_stat.bad ? ST_DONE : ST_FETCH;
            end
            ST_FETCH: n_state = ST_EXEC1;
            ST_EXEC1: begin
                if (i_stat.op == OP_ADD && i_stat.whole) begin
                    n_state = i_stat.range_end ? ST_DONE : ST_FETCH;
                end else begin
                    n_state = ST_EXEC2;
                end
            end
            ST_EXEC2: begin
                if (i_stat.op == OP_LOAD) begin
                    n_state = ST_EXEC3;
                end else begin
                    n_state = i_stat.range_end ? ST_DONE : ST_FETCH;
                end
            end
            ST_EXEC3: n_state = ST_DONE;
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.asel = A_V;
        o_ctrl.bsel = B_V;
        unique case (r_state)
            ST_CLEAR: begin
                o_ctrl.clearing = 1'b1;
                o_ctrl.wr_elem  = 1'b1;
                o_ctrl.wr_tag   = 1'b1;
                o_ctrl.wr_sum   = 1'b1;
            end
            ST_IDLE: o_ctrl.ready = 1'b1;
            ST_FETCH: ;
            ST_EXEC1: begin
                unique case (i_stat.op)
                    OP_LOAD: begin
                        // Stored value excludes the block's pending tag.
                        o_ctrl.asel    = A_V;
                        o_ctrl.bsel    = B_TAG;
                        o_ctrl.alu_sub = 1'b1;
                        o_ctrl.ld_tmp  = 1'b1;
                    end
                    OP_ADD: begin
                        if (i_stat.whole) begin
                            o_ctrl.asel    = A_V;
                            o_ctrl.bsel    = B_TAG;
                            o_ctrl.wr_tag  = 1'b1;
                            o_ctrl.advance = 1'b1;
                        end else begin
                            o_ctrl.asel    = A_ELEM;
                            o_ctrl.bsel    = B_V;
                            o_ctrl.wr_elem = 1'b1;
                        end
                    end
                    OP_QUERY: begin
                        o_ctrl.asel   = i_stat.whole ? A_SUM : A_ELEM;
                        o_ctrl.bsel   = i_stat.whole ? B_TAG32 : B_TAG;
                        o_ctrl.ld_tmp = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_EXEC2: begin
                unique case (i_stat.op)
                    OP_LOAD: begin
                        o_ctrl.wr_elem       = 1'b1;
                        o_ctrl.elem_from_tmp = 1'b1;
                        o_ctrl.asel          = A_TMP;
                        o_ctrl.bsel          = B_ELEM;
                        o_ctrl.alu_sub       = 1'b1;
                        o_ctrl.ld_tmp        = 1'b1;
                    end
                    OP_ADD: begin
                        o_ctrl.asel    = A_SUM;
                        o_ctrl.bsel    = B_V;
                        o_ctrl.wr_sum  = 1'b1;
                        o_ctrl.advance = 1'b1;
                    end
                    OP_QUERY: begin
                        o_ctrl.asel    = A_ACC;
                        o_ctrl.bsel    = B_TMP;
                        o_ctrl.ld_acc  = 1'b1;
                        o_ctrl.advance = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_EXEC3: begin
                o_ctrl.asel   = A_SUM;
                o_ctrl.bsel   = B_TMP;
                o_ctrl.wr_sum = 1'b1;
            end
            ST_DONE: o_ctrl.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[hdl/block_range_add_range_sum.sv]
// Top level of the blocked range-add / range-sum engine: ports, memories, datapath.
// Depends on brs_pkg, brs_alu and brs_seq.
//
//  channel   | direction | fields (lowest bit first)
//  s_axis    | in        | tuser: operation; tdata: left_index, right_index, operand_value
//  m_axis    | out       | tuser: status; tdata: range_sum
//  cfg       | in        | data: element_count
//
// After reset a clearing pass zeroes the memories; no request is taken meanwhile, configuration writes are.
// A load and every step of a range request pass through the shared adder in turn, after
// a memory read at each position; a range request steps over edge elements one at a
// time and over a whole block at once.
// The next request is taken once the previous result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module block_range_add_range_sum (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [87:0]  i_s_axis_tdata,   // left_index, right_index, operand_value, zero pad
    input  wire [1:0]   i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // range_sum
    output logic        o_m_axis_tuser,   // status
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [10:0]  i_cfg_data        // element_count
);
    import brs_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [DATA_W-1:0] tag_mem  [NUM_BLOCKS];
    logic [DATA_W-1:0] sum_mem  [NUM_BLOCKS];

    logic [DATA_W-1:0]  r_elem_q;
    logic [DATA_W-1:0]  r_tag_q;
    logic [DATA_W-1:0]  r_sum_q;
    logic [FIELD_W-1:0] r_count;
    logic [IDX_W-1:0]   r_clr;
    logic [OP_W-1:0]    r_op;
    logic [POS_W-1:0]   r_pos;
    logic [IDX_W-1:0]   r_last;
    logic [DATA_W-1:0]  r_v;
    logic [DATA_W-1:0]  r_tmp;
    logic [DATA_W-1:0]  r_acc;
    logic               r_status;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_sum;
    logic               r_out_status;

    logic [OP_W-1:0]    in_op;
    logic [FIELD_W-1:0] in_l;
    logic [FIELD_W-1:0] in_r;
    logic [DATA_W-1:0]  in_v;
    logic [FIELD_W-1:0] eff_n;
    logic [FIELD_W-1:0] l_m1;
    logic [FIELD_W-1:0] r_m1;
    logic               bad;
    logic               accept;
    logic [POS_W-1:0]   step;
    logic [POS_W-1:0]   next_pos;
    logic [IDX_W-1:0]   elem_addr;
    logic [BLK_W-1:0]   blk_addr;
    logic [DATA_W-1:0]  elem_wdata;
    logic [DATA_W-1:0]  blk_wdata;
    logic [DATA_W-1:0]  alu_y;

    assign in_op = i_s_axis_tuser;
    assign in_l  = i_s_axis_tdata[10:0];
    assign in_r  = i_s_axis_tdata[21:11];
    assign in_v  = i_s_axis_tdata[85:22];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = ctrl.ready;
    assign accept          = i_s_axis_tvalid && ctrl.ready;

    assign eff_n = (r_count > COUNT_MAX) ? COUNT_MAX : r_count;
    assign l_m1  = in_l - FIELD_W'(1);
    assign r_m1  = in_r - FIELD_W'(1);

    always_comb begin
        if (in_op == OP_BAD || in_l == '0 || in_l > eff_n) begin
            bad = 1'b1;
        end else if (in_op == OP_LOAD) begin
            bad = 1'b0;
        end else begin
            bad = (in_l > in_r) || (in_r > eff_n);
        end
    end

    // A block is handled whole when the walk enters it at its first element
    // and the range reaches its last element.
    assign stat.whole     = (r_pos[OFF_W-1:0] == '0)
                            && ({1'b0, r_last} >= r_pos + POS_W'(BLOCK_SIZE - 1));
    assign step           = stat.whole ? POS_W'(BLOCK_SIZE) : POS_W'(1);
    assign next_pos       = r_pos + step;
    assign stat.range_end = next_pos > {1'b0, r_last};
    assign stat.accept    = accept;
    assign stat.bad       = bad;
    assign stat.clr_done  = (r_clr == '1);
    assign stat.op        = r_op;
    assign stat.out_free  = !r_out_valid || i_m_axis_tready;

    brs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    brs_alu u_alu (
        .i_asel (ctrl.asel),
        .i_bsel (ctrl.bsel),
        .i_sub  (ctrl.alu_sub),
        .i_v    (r_v),
        .i_elem (r_elem_q),
        .i_sum  (r_sum_q),
        .i_tag  (r_tag_q),
        .i_tmp  (r_tmp),
        .i_acc  (r_acc),
        .o_y    (alu_y)
    );

    assign elem_addr  = ctrl.clearing ? r_clr : r_pos[IDX_W-1:0];
    assign blk_addr   = ctrl.clearing ? r_clr[BLK_W-1:0] : r_pos[IDX_W-1:OFF_W];
    assign elem_wdata = ctrl.clearing ? '0 : (ctrl.elem_from_tmp ? r_tmp : alu_y);
    assign blk_wdata  = ctrl.clearing ? '0 : alu_y;

    always_ff @(posedge i_clk) begin
        if (ctrl.wr_elem) begin
            elem_mem[elem_addr] <= elem_wdata;
        end
        r_elem_q <= elem_mem[elem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.wr_tag) begin
            tag_mem[blk_addr] <= blk_wdata;
        end
        r_tag_q <= tag_mem[blk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.wr_sum) begin
            sum_mem[blk_addr] <= blk_wdata;
        end
        r_sum_q <= sum_mem[blk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (ctrl.clearing) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= in_op;
            r_pos    <= l_m1;
            r_last   <= r_m1[IDX_W-1:0];
            r_v      <= in_v;
            r_acc    <= '0;
            r_status <= bad;
        end else begin
            if (ctrl.advance) begin
                r_pos <= next_pos;
            end
            if (ctrl.ld_acc) begin
                r_acc <= alu_y;
            end
        end
        if (ctrl.ld_tmp) begin
            r_tmp <= alu_y;
        end
        if (ctrl.out_load) begin
            r_out_sum    <= (r_op == OP_QUERY) ? r_acc : '0;
            r_out_status <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sum;
    assign o_m_axis_tuser  = r_out_status;

    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("flagged request returned a nonzero sum");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.wr_elem && !ctrl.clearing && r_op != OP_LOAD) |-> (r_pos <= {1'b0, r_last}))
        else $error("element update outside the requested range");

    a_tag_on_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.wr_tag && !ctrl.clearing) |-> (r_pos[OFF_W-1:0] == '0))
        else $error("block tag written away from a block boundary");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("new request taken while one is in progress");

endmodule

`default_nettype wire

[tb/sv/range_sum_checker.sv]
`timescale 1ns / 1ps
// Checker for block_range_add_range_sum: watches the request, result and count-write
// channels, predicts every result from a flat copy of the array and compares them.
// Depends on brs_pkg.

module range_sum_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  wire [87:0]  i_req_data,     // left_index, right_index, operand_value, zero pad
    input  wire [1:0]   i_req_op,       // operation
    input  wire         i_res_valid,
    input  wire         i_res_ready,
    input  wire [63:0]  i_res_sum,      // range_sum
    input  wire         i_res_status,   // status
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire [10:0]  i_cfg_data,     // element_count
    output int          o_pending,
    output int          o_failures
);
    import brs_pkg::*;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              status;
    } t_outcome;

    // Full element values; a block tag in the design is folded in here directly.
    logic [DATA_W-1:0]  element_vals [1:MAX_ELEMENTS];
    logic [FIELD_W-1:0] element_count;
    t_outcome           expected_q [$];

    function automatic t_outcome apply_request(
        input logic [OP_W-1:0]    op,
        input logic [FIELD_W-1:0] left,
        input logic [FIELD_W-1:0] right,
        input logic [DATA_W-1:0]  amount
    );
        t_outcome res;
        int       n;
        res.sum    = '0;
        res.status = STATUS_BAD;
        n = (element_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(element_count);
        if (op == OP_LOAD) begin
            if (left != 0 && left <= n) begin
                element_vals[left] = amount;
                res.status = STATUS_DONE;
            end
        end else if (op != OP_BAD && left != 0 && left <= right && right <= n) begin
            for (int i = left; i <= right; i++) begin
                if (op == OP_ADD)
                    element_vals[i] += amount;
                else
                    res.sum += element_vals[i];
            end
            res.status = STATUS_DONE;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 1; i <= MAX_ELEMENTS; i++)
                element_vals[i] = '0;
            element_count = COUNT_RESET;
            expected_q.delete();
            o_failures = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding: range_sum %h status %0d",
                           i_res_sum, i_res_status);
                    o_failures++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_res_sum !== want.sum) begin
                        $error("range_sum mismatch: expected %h, actual %h",
                               want.sum, i_res_sum);
                        o_failures++;
                    end
                    if (i_res_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_res_status);
                        o_failures++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                element_count = i_cfg_data;
            if (i_req_valid && i_req_ready)
                expected_q.push_back(apply_request(i_req_op, i_req_data[10:0],
                                                   i_req_data[21:11], i_req_data[85:22]));
        end
        o_pending = expected_q.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the block_range_add_range_sum testbench: clock, reset, requests, count writes
// and the verdict. Depends on brs_pkg, the design and range_sum_checker.

module tb_top;
    import brs_pkg::*;

    localparam int CLOCK_LIMIT = 2_000_000;
    localparam int NUM_PHASES  = 8;

    logic         clk        = 1'b0;
    logic         rst_n      = 1'b0;
    logic         req_valid  = 1'b0;
    logic [87:0]  req_data   = '0;
    logic [1:0]   req_op     = OP_LOAD;
    logic         res_ready  = 1'b0;
    logic         cfg_valid  = 1'b0;
    logic [10:0]  cfg_data   = '0;
    wire          req_ready;
    wire          res_valid;
    wire  [63:0]  res_sum;
    wire          res_status;
    wire          cfg_ready;
    int           pending;
    int           failures;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cur_count    = 1024;

    int phase_count [NUM_PHASES] = '{1024, 1, 2047, 0, 33, 1000, 64, 1024};
    int phase_items [NUM_PHASES] = '{250, 100, 250, 50, 200, 250, 250, 250};
    int mode_tx_idle [4] = '{0, 70, 0, 25};
    int mode_rx_stall [4] = '{0, 0, 70, 25};

    block_range_add_range_sum dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_op),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_sum),
        .o_m_axis_tuser  (res_status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    range_sum_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_req_op     (req_op),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_sum    (res_sum),
        .i_res_status (res_status),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_failures   (failures)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        res_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Each task is entered just after a rising edge and returns just after one.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [10:0] left,
                                input logic [10:0] right, input logic [63:0] amount);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_data  <= {2'b00, amount, right, left};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic write_count(input int count);
        cfg_valid <= 1'b1;
        cfg_data  <= 11'(count);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_count = count;
    endtask

    // The checker updates its queue at the rising edge, so it is read at the falling one.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_operand();
        case ($urandom_range(9))
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'h0;
            4, 5, 6: return 64'(int'($urandom_range(2000)) - 1000);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic pick_range(input int n, output logic [10:0] left, output logic [10:0] right);
        int kind, a, b, top_blk;
        kind = $urandom_range(99);
        if (n == 0 || kind >= 88) begin
            left  = 11'($urandom);
            right = 11'($urandom);
        end else if (kind < 40) begin
            a = $urandom_range(n, 1);
            b = a + $urandom_range(40);
            left  = 11'(a);
            right = 11'((b > n) ? n : b);
        end else if (kind < 60) begin
            // Block-aligned ranges so that whole blocks are tagged and summed.
            top_blk = (n - 1) / BLOCK_SIZE;
            a = $urandom_range(top_blk);
            b = $urandom_range(top_blk, a);
            left  = 11'(a * BLOCK_SIZE + 1);
            right = 11'(((b + 1) * BLOCK_SIZE > n) ? n : (b + 1) * BLOCK_SIZE);
        end else if (kind < 75) begin
            a = $urandom_range(n, 1);
            b = $urandom_range(n, 1);
            left  = 11'((a < b) ? a : b);
            right = 11'((a < b) ? b : a);
        end else if (kind < 80) begin
            left  = 11'd1;
            right = 11'(n);
        end else begin
            case ($urandom_range(2))
                0: begin
                    left  = 11'd0;
                    right = 11'($urandom_range(n));
                end
                1: begin
                    a = $urandom_range(n, 1);
                    left  = 11'(a + 1);
                    right = 11'(a);
                end
                default: begin
                    left  = 11'($urandom_range(n, 1));
                    right = 11'($urandom_range(2047, n + 1));
                end
            endcase
        end
    endtask

    task automatic send_random();
        int                n, pick;
        logic [10:0]       left, right;
        logic [OP_W-1:0]   op;
        n = (cur_count > MAX_ELEMENTS) ? MAX_ELEMENTS : cur_count;
        pick = $urandom_range(99);
        if (pick < 30) begin
            op = OP_LOAD;
            left  = (n > 0 && $urandom_range(9) != 0) ? 11'($urandom_range(n, 1))
                                                      : 11'($urandom);
            right = 11'($urandom);
        end else begin
            op = (pick < 60) ? OP_ADD : (pick < 97) ? OP_QUERY : OP_BAD;
            pick_range(n, left, right);
        end
        send_request(op, left, right, random_operand());
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run at the reset element count.
        send_request(OP_QUERY, 11'd1,    11'd1024, 64'h0);
        send_request(OP_LOAD,  11'd1,    11'd0,    64'h7FFF_FFFF_FFFF_FFFF);
        send_request(OP_LOAD,  11'd1024, 11'd2047, 64'h8000_0000_0000_0000);
        send_request(OP_LOAD,  11'd0,    11'd5,    64'h55);
        send_request(OP_LOAD,  11'd1025, 11'd5,    64'h66);
        send_request(OP_ADD,   11'd1,    11'd1024, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_ADD,   11'd3,    11'd5,    64'd5);
        send_request(OP_ADD,   11'd30,   11'd70,   64'h1_2345_6789);
        send_request(OP_ADD,   11'd33,   11'd64,   64'd7);
        // A load into a tagged block must read back as the loaded value.
        send_request(OP_LOAD,  11'd40,   11'd0,    64'd1234);
        send_request(OP_QUERY, 11'd40,   11'd40,   64'h0);
        send_request(OP_QUERY, 11'd1,    11'd1,    64'h0);
        send_request(OP_QUERY, 11'd1024, 11'd1024, 64'h0);
        send_request(OP_QUERY, 11'd1,    11'd1024, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_QUERY, 11'd31,   11'd66,   64'h0);
        send_request(OP_ADD,   11'd0,    11'd5,    64'd9);
        send_request(OP_QUERY, 11'd10,   11'd9,    64'h0);
        send_request(OP_QUERY, 11'd5,    11'd1025, 64'h0);
        send_request(OP_BAD,   11'd1,    11'd1,    64'd3);
        send_request(OP_ADD,   11'd2047, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_QUERY, 11'd1,    11'd2047, 64'h0);
        send_request(OP_QUERY, 11'd33,   11'd64,   64'h0);
        wait_for_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            tx_idle_pct = mode_tx_idle[p % 4];
            rx_stall_pct <= mode_rx_stall[p % 4];
            write_count(phase_count[p]);
            for (int k = 0; k < phase_items[p]; k++)
                send_random();
            wait_for_results();
        end

        repeat (256) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CLOCK_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

[block_range_add_range_sum.f]
hdl/brs_pkg.sv
hdl/brs_alu.sv
hdl/brs_seq.sv
hdl/block_range_add_range_sum.sv
tb/sv/range_sum_checker.sv
tb/sv/tb_top.sv
